/* hw/rtl/mfbfs_pkg.sv */
// shared types and constants for the breadth-first max flow block
package mfbfs_pkg;

    localparam int FLOW_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_COUNT  = 2'd0,
        CFG_SOURCE_VERTEX = 2'd1,
        CFG_SINK_VERTEX   = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_BFS_INIT,
        S_POP,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_BN_PAR,
        S_BN_PAR_WAIT,
        S_BN_RES,
        S_AUG_PAR,
        S_AUG_PAR_WAIT,
        S_AUG_FWD,
        S_AUG_BWD,
        S_FLOW,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/max_flow_bfs_augment.sv */
// breadth-first augmenting path max flow over a residual capacity memory
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata: from, to, capacity; tlast: last edge
//  m_axis    out  m_axis_tvalid/tready    tdata: total flow
//  cfg       in   cfg_wr_en               cfg_index, cfg_wr_data
//
// edge items are accepted in the idle state; the item with tlast starts the solve
// each search pops a vertex in S_POP and S_POP_WAIT and reads each candidate in S_SCAN_RD
// and S_SCAN_CHK; each augmenting path is walked for its bottleneck and then updated,
// steps set by the residual memory with one read port and one write port
// after reset and after each result a clearing pass over all MAX_VERTICES^2 entries
// zeroes the residual memory; no item is taken during the pass or the solve
// a result waits in its output register; a new solve holds before writing it
module max_flow_bfs_augment
    import mfbfs_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int CAP_BITS     = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [3:0] from_vertex, [7:4] to_vertex, [23:8] capacity
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [19:0] total flow, [23:20] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NW    = VW + 1;
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = CAP_BITS + 1;
    localparam int TW    = FLOW_W + 1;
    localparam int SW    = ((TW > RW) ? TW : RW) + 1;

    localparam logic [RW-1:0] CAP_MASK = {1'b0, {CAP_BITS{1'b1}}};
    localparam logic [SW-1:0] SUM_MAX  = SW'(FLOW_MAX);

    function automatic logic [AW-1:0] addr_of(input logic [VW-1:0] u, input logic [VW-1:0] v);
        addr_of = AW'(u * MAX_VERTICES + v);
    endfunction

    state_t state_reg, state_next;

    logic [4:0] vertex_count_reg;
    logic [3:0] source_vertex_reg;
    logic [3:0] sink_vertex_reg;

    logic [AW-1:0]       clr_reg, clr_next;
    logic [NW-1:0]       head_reg, head_next;
    logic [NW-1:0]       tail_reg, tail_next;
    logic [VW-1:0]       u_reg, u_next;
    logic [VW-1:0]       v_reg, v_next;
    logic [MAX_VERTICES-1:0] seen_reg, seen_next;
    logic [RW-1:0]       bott_reg, bott_next;
    logic [TW-1:0]       flow_reg, flow_next;
    logic                out_valid_reg, out_valid_next;
    logic [FLOW_W-1:0]   out_data_reg, out_data_next;

    // residual memory
    logic [RW-1:0] res_mem [DEPTH];
    logic          res_we;
    logic [AW-1:0] res_wa, res_ra;
    logic [RW-1:0] res_wd, res_rd;

    // predecessor memory
    logic [VW-1:0] par_mem [MAX_VERTICES];
    logic          par_we;
    logic [VW-1:0] par_wa, par_ra, par_wd, par_rd;

    // breadth-first queue
    logic [VW-1:0] fr_mem [MAX_VERTICES];
    logic          fr_we;
    logic [VW-1:0] fr_wa, fr_ra, fr_wd, fr_rd;

    logic [NW-1:0]       n_w;
    logic [VW-1:0]       src_w, dst_w;
    logic                trivial_w;
    logic                in_acc;
    logic                edge_ok;
    logic [3:0]          from_w, to_w;
    logic [RW+15:0]      cap_ext;
    logic [RW-1:0]       cap_w;
    logic                v_last;
    logic [SW-1:0]       sum_w;

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_wa] <= res_wd;
        end
        res_rd <= res_mem[res_ra];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_wa] <= par_wd;
        end
        par_rd <= par_mem[par_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fr_we)
        begin
            fr_mem[fr_wa] <= fr_wd;
        end
        fr_rd <= fr_mem[fr_ra];
    end

    always_comb
    begin
        n_w = (32'(vertex_count_reg) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                     : NW'(vertex_count_reg);
        src_w = VW'(source_vertex_reg);
        dst_w = VW'(sink_vertex_reg);
        trivial_w = (32'(source_vertex_reg) >= 32'(n_w)) ||
                    (32'(sink_vertex_reg) >= 32'(n_w)) ||
                    (source_vertex_reg == sink_vertex_reg);
        from_w  = s_axis_tdata[3:0];
        to_w    = s_axis_tdata[7:4];
        cap_ext = {{RW{1'b0}}, s_axis_tdata[23:8]};
        cap_w   = cap_ext[RW-1:0] & CAP_MASK;
        edge_ok = (32'(from_w) < MAX_VERTICES) && (32'(to_w) < MAX_VERTICES);
        in_acc  = s_axis_tvalid && s_axis_tready;
        v_last  = (NW'(v_reg) + NW'(1)) == n_w;
        sum_w   = SW'(flow_reg) + SW'(bott_reg);
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-FLOW_W){1'b0}}, out_data_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = trivial_w ? S_DONE : S_BFS_INIT;
            end
            S_BFS_INIT:
            begin
                state_next = S_POP;
            end
            S_POP:
            begin
                state_next = (head_reg == tail_reg) ? S_DONE : S_POP_WAIT;
            end
            S_POP_WAIT:
            begin
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (!seen_reg[v_reg] && (res_rd != '0) && (v_reg == dst_w))
                begin
                    state_next = S_BN_PAR;
                end
                else if (v_last)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_BN_PAR:
            begin
                state_next = (v_reg == src_w) ? S_AUG_PAR : S_BN_PAR_WAIT;
            end
            S_BN_PAR_WAIT:
            begin
                state_next = S_BN_RES;
            end
            S_BN_RES:
            begin
                state_next = S_BN_PAR;
            end
            S_AUG_PAR:
            begin
                state_next = (v_reg == src_w) ? S_FLOW : S_AUG_PAR_WAIT;
            end
            S_AUG_PAR_WAIT:
            begin
                state_next = S_AUG_FWD;
            end
            S_AUG_FWD:
            begin
                state_next = S_AUG_BWD;
            end
            S_AUG_BWD:
            begin
                state_next = S_AUG_PAR;
            end
            S_FLOW:
            begin
                state_next = S_BFS_INIT;
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    state_next = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        clr_next       = clr_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        seen_next      = seen_reg;
        bott_next      = bott_reg;
        flow_next      = flow_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        res_we = 1'b0;
        res_wa = addr_of(u_reg, v_reg);
        res_wd = '0;
        res_ra = addr_of(u_reg, v_reg);
        par_we = 1'b0;
        par_wa = v_reg;
        par_wd = u_reg;
        par_ra = v_reg;
        fr_we  = 1'b0;
        fr_wa  = VW'(tail_reg);
        fr_wd  = v_reg;
        fr_ra  = VW'(head_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                res_we   = 1'b1;
                res_wa   = clr_reg;
                clr_next = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                clr_next = '0;
                if (in_acc && edge_ok)
                begin
                    res_we = 1'b1;
                    res_wa = addr_of(VW'(from_w), VW'(to_w));
                    res_wd = cap_w;
                end
            end
            S_START:
            begin
                flow_next = '0;
            end
            S_BFS_INIT:
            begin
                seen_next        = '0;
                seen_next[src_w] = 1'b1;
                fr_we     = 1'b1;
                fr_wa     = '0;
                fr_wd     = src_w;
                head_next = '0;
                tail_next = NW'(1);
            end
            S_POP:
            begin
                head_next = head_reg + NW'(1);
            end
            S_POP_WAIT:
            begin
                u_next = fr_rd;
                v_next = '0;
            end
            S_SCAN_RD:
            begin
            end
            S_SCAN_CHK:
            begin
                if (!seen_reg[v_reg] && (res_rd != '0))
                begin
                    par_we            = 1'b1;
                    seen_next[v_reg]  = 1'b1;
                    if (v_reg != dst_w && 32'(tail_reg) < MAX_VERTICES)
                    begin
                        fr_we     = 1'b1;
                        tail_next = tail_reg + NW'(1);
                    end
                end
                if (v_reg == dst_w && !seen_reg[v_reg] && (res_rd != '0))
                begin
                    bott_next = '1;
                end
                else
                begin
                    v_next = v_reg + VW'(1);
                end
            end
            S_BN_PAR:
            begin
                if (v_reg == src_w)
                begin
                    v_next = dst_w;
                end
            end
            S_BN_PAR_WAIT:
            begin
                u_next = par_rd;
                res_ra = addr_of(par_rd, v_reg);
            end
            S_BN_RES:
            begin
                if (res_rd < bott_reg)
                begin
                    bott_next = res_rd;
                end
                v_next = u_reg;
            end
            S_AUG_PAR:
            begin
            end
            S_AUG_PAR_WAIT:
            begin
                u_next = par_rd;
                res_ra = addr_of(par_rd, v_reg);
            end
            S_AUG_FWD:
            begin
                res_we = 1'b1;
                res_wa = addr_of(u_reg, v_reg);
                res_wd = res_rd - bott_reg;
                res_ra = addr_of(v_reg, u_reg);
            end
            S_AUG_BWD:
            begin
                res_we = 1'b1;
                res_wa = addr_of(v_reg, u_reg);
                res_wd = res_rd + bott_reg;
                v_next = u_reg;
            end
            S_FLOW:
            begin
                // saturate one past the largest reportable total
                flow_next = (sum_w > SUM_MAX) ? TW'(SUM_MAX + SW'(1)) : TW'(sum_w);
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = flow_reg[FLOW_W] ? FLOW_MAX : flow_reg[FLOW_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_reg           <= '0;
            out_valid_reg     <= 1'b0;
            vertex_count_reg  <= 5'd16;
            source_vertex_reg <= 4'd0;
            sink_vertex_reg   <= 4'd15;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_VERTEX_COUNT:  vertex_count_reg  <= cfg_wr_data;
                    CFG_SOURCE_VERTEX: source_vertex_reg <= cfg_wr_data[3:0];
                    CFG_SINK_VERTEX:   sink_vertex_reg   <= cfg_wr_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        seen_reg     <= seen_next;
        bott_reg     <= bott_next;
        flow_reg     <= flow_next;
        out_data_reg <= out_data_next;
    end

endmodule
